// File: rtl/erspl_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths, opcodes and error codes of the erase range splitter.
package erspl_pkg;

  // Flash address width; run addresses wrap modulo 2**ADDR_BITS
  localparam int ADDR_BITS = 25;

  // Field widths
  localparam int OFF_W  = 25;
  localparam int LEN_W  = 26;
  localparam int OP_W   = 8;
  localparam int ADDR_W = 25;
  localparam int CNT_W  = 10;
  localparam int ERR_W  = 2;

  // Stream data widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - (OP_W + ADDR_W + CNT_W + ERR_W);

  // Length in 4K sectors
  localparam int UNIT_W = LEN_W - 12;

  // Address bits that survive the wrap
  localparam int ADDR_KEEP = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] RUN_ADDR_MASK =
    ADDR_W'((64'(1) << ADDR_KEEP) - 64'(1));

  // Erase opcodes
  localparam logic [OP_W-1:0] OP_NONE   = 8'h00;
  localparam logic [OP_W-1:0] OP_SECTOR = 8'h20;
  localparam logic [OP_W-1:0] OP_BLK32  = 8'h52;
  localparam logic [OP_W-1:0] OP_BLK64  = 8'hd8;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNALIGNED = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SHORT     = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NOT_MULT  = 2'd3;

  // Run slots, in issue order
  localparam int SLOTS  = 5;
  localparam int SLOT_W = 3;
  localparam logic [SLOT_W-1:0] SLOT_HEAD_S   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_HEAD_B32 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_BLK64    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_B32 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_S   = 3'd4;

  // Plan queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // One classified request: raw pieces for address stepping, merged run counts
  typedef struct packed {
    logic [ERR_W-1:0]             err;
    logic [OFF_W-1:0]             off;
    logic [3:0]                   hs;        // head sectors before merge
    logic                         hb;        // head 32K block
    logic [CNT_W-1:0]             c64;       // 64K blocks
    logic                         t32;       // tail 32K block before merge
    logic [SLOTS-1:0][CNT_W-1:0]  cnt;       // merged count per slot
    logic [SLOT_W-1:0]            last_slot; // highest slot with a run
  } plan_t;

endpackage

// File: rtl/erspl_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, checks them and splits the range into run slots.
module erspl_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [erspl_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                               plan_valid,
  input  logic                               plan_ready,
  output erspl_pkg::plan_t                   plan
);

  localparam int UW = erspl_pkg::UNIT_W;

  // Request fields
  logic [erspl_pkg::OFF_W-1:0] off_in;
  logic [erspl_pkg::LEN_W-1:0] len_in;
  assign off_in = in_tdata[erspl_pkg::OFF_W-1:0];
  assign len_in = in_tdata[erspl_pkg::OFF_W +: erspl_pkg::LEN_W];

  logic [erspl_pkg::ERR_W-1:0] err_in;
  logic [UW-1:0]               units;
  logic [3:0]                  sub64;
  logic [3:0]                  head_left;
  logic [3:0]                  hs1_in;
  logic [UW-1:0]               l1_in;
  logic                        need32_in;

  // Check alignment and length, and take sectors up to the next 32K boundary
  always_comb begin
    priority if (off_in[11:0] != 12'd0) begin
      err_in = erspl_pkg::ERR_UNALIGNED;
    end else if (len_in[erspl_pkg::LEN_W-1:12] == '0) begin
      err_in = erspl_pkg::ERR_SHORT;
    end else if (len_in[11:0] != 12'd0) begin
      err_in = erspl_pkg::ERR_NOT_MULT;
    end else begin
      err_in = erspl_pkg::ERR_NONE;
    end
    units     = len_in[erspl_pkg::LEN_W-1:12];
    sub64     = off_in[15:12];
    head_left = 4'd8 - {1'b0, sub64[2:0]};
    if (sub64[2:0] == 3'd0) begin
      hs1_in = 4'd0;
    end else if (units < UW'(head_left)) begin
      hs1_in = units[3:0];
    end else begin
      hs1_in = head_left;
    end
    l1_in     = units - UW'(hs1_in);
    // lower 32K half unaligned, or exactly on the upper half: a 32K block may follow
    need32_in = (sub64[2:0] != 3'd0) ? !sub64[3] : sub64[3];
  end

  // Stage one registers
  logic                        s1_valid_r, s1_valid_nxt;
  logic [erspl_pkg::ERR_W-1:0] s1_err_r;
  logic [erspl_pkg::OFF_W-1:0] s1_off_r;
  logic [3:0]                  s1_hs1_r;
  logic [UW-1:0]               s1_l1_r;
  logic                        s1_need32_r;

  assign in_tready = !s1_valid_r || plan_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_err_r    <= err_in;
      s1_off_r    <= off_in;
      s1_hs1_r    <= hs1_in;
      s1_l1_r     <= l1_in;
      s1_need32_r <= need32_in;
    end
  end

  // Finish the head, split the rest into 64K, 32K and 4K pieces, merge neighbors
  logic [3:0]    hs;
  logic          hb;
  logic [UW-1:0] rem;
  logic          merge_b;
  logic          merge_s;

  always_comb begin
    if (s1_need32_r && (s1_l1_r != '0)) begin
      if (s1_l1_r[UW-1:3] != '0) begin
        hs  = s1_hs1_r;
        hb  = 1'b1;
        rem = s1_l1_r - UW'(8);
      end else begin
        hs  = s1_hs1_r + s1_l1_r[3:0];
        hb  = 1'b0;
        rem = '0;
      end
    end else begin
      hs  = s1_hs1_r;
      hb  = 1'b0;
      rem = s1_l1_r;
    end

    plan.err = s1_err_r;
    plan.off = s1_off_r;
    plan.hs  = hs;
    plan.hb  = hb;
    plan.c64 = rem[UW-1:4];
    plan.t32 = rem[3];

    merge_b = hb && (rem[UW-1:4] == '0) && rem[3];
    merge_s = (hs != 4'd0) && !hb && (rem[UW-1:3] == '0) && (rem[2:0] != 3'd0);

    plan.cnt[erspl_pkg::SLOT_HEAD_S] = erspl_pkg::CNT_W'(hs)
      + (merge_s ? erspl_pkg::CNT_W'(rem[2:0]) : '0);
    plan.cnt[erspl_pkg::SLOT_HEAD_B32] = hb ? (merge_b ? erspl_pkg::CNT_W'(2)
                                                       : erspl_pkg::CNT_W'(1)) : '0;
    plan.cnt[erspl_pkg::SLOT_BLK64]    = rem[UW-1:4];
    plan.cnt[erspl_pkg::SLOT_TAIL_B32] = erspl_pkg::CNT_W'(rem[3] && !merge_b);
    plan.cnt[erspl_pkg::SLOT_TAIL_S]   = merge_s ? '0 : erspl_pkg::CNT_W'(rem[2:0]);

    // Last slot that carries a run
    priority if (plan.cnt[erspl_pkg::SLOT_TAIL_S] != '0) begin
      plan.last_slot = erspl_pkg::SLOT_TAIL_S;
    end else if (plan.cnt[erspl_pkg::SLOT_TAIL_B32] != '0) begin
      plan.last_slot = erspl_pkg::SLOT_TAIL_B32;
    end else if (plan.cnt[erspl_pkg::SLOT_BLK64] != '0) begin
      plan.last_slot = erspl_pkg::SLOT_BLK64;
    end else if (plan.cnt[erspl_pkg::SLOT_HEAD_B32] != '0) begin
      plan.last_slot = erspl_pkg::SLOT_HEAD_B32;
    end else begin
      plan.last_slot = erspl_pkg::SLOT_HEAD_S;
    end
  end

  assign plan_valid = s1_valid_r;

endmodule

// File: rtl/erspl_queue.sv
`timescale 1ns / 1ps
// Two-entry plan queue between the front end and the run sequencer.
module erspl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  erspl_pkg::plan_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output erspl_pkg::plan_t pop_data
);

  erspl_pkg::plan_t                 mem_r [erspl_pkg::QDEPTH];
  logic [erspl_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [erspl_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [erspl_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                             push;
  logic                             pop;

  assign push_ready = count_r != erspl_pkg::QCNT_W'(erspl_pkg::QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/erspl_back.sv
`timescale 1ns / 1ps
// Back end: walks the run slots of one plan and drives the result stream.
module erspl_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              plan_valid,
  output logic                              plan_ready,
  input  erspl_pkg::plan_t                  plan,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [erspl_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  function automatic logic [erspl_pkg::OP_W-1:0] slot_opcode(
    input logic [erspl_pkg::SLOT_W-1:0] slot
  );
    logic [erspl_pkg::OP_W-1:0] op;
    unique case (slot)
      erspl_pkg::SLOT_HEAD_S:   op = erspl_pkg::OP_SECTOR;
      erspl_pkg::SLOT_HEAD_B32: op = erspl_pkg::OP_BLK32;
      erspl_pkg::SLOT_BLK64:    op = erspl_pkg::OP_BLK64;
      erspl_pkg::SLOT_TAIL_B32: op = erspl_pkg::OP_BLK32;
      erspl_pkg::SLOT_TAIL_S:   op = erspl_pkg::OP_SECTOR;
      default:                  op = erspl_pkg::OP_NONE;
    endcase
    return op;
  endfunction

  logic                           busy_r, busy_nxt;
  logic [erspl_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [erspl_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  erspl_pkg::plan_t               cur_r, cur_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [erspl_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           is_err;
  logic                           out_free;
  logic                           emit;
  logic                           step;
  logic                           final_slot;
  logic                           done;
  logic [erspl_pkg::ADDR_W-1:0]   span;
  logic [erspl_pkg::OP_W-1:0]     r_op;
  logic [erspl_pkg::ADDR_W-1:0]   r_addr;
  logic [erspl_pkg::CNT_W-1:0]    r_cnt;

  assign is_err     = cur_r.err != erspl_pkg::ERR_NONE;
  assign out_free   = !out_valid_r || out_tready;
  assign emit       = is_err ? (slot_r == erspl_pkg::SLOT_HEAD_S)
                             : (cur_r.cnt[slot_r] != '0);
  assign step       = busy_r && (!emit || out_free);
  assign final_slot = is_err || (slot_r == cur_r.last_slot);
  assign done       = step && final_slot;
  assign plan_ready = !busy_r || done;

  // Byte span of the current slot before merging
  always_comb begin
    unique case (slot_r)
      erspl_pkg::SLOT_HEAD_S:   span = erspl_pkg::ADDR_W'({cur_r.hs, 12'd0});
      erspl_pkg::SLOT_HEAD_B32: span = erspl_pkg::ADDR_W'({cur_r.hb, 15'd0});
      erspl_pkg::SLOT_BLK64:    span = erspl_pkg::ADDR_W'({cur_r.c64, 16'd0});
      erspl_pkg::SLOT_TAIL_B32: span = erspl_pkg::ADDR_W'({cur_r.t32, 15'd0});
      default:                  span = '0;
    endcase
  end

  // Result fields for the current slot
  always_comb begin
    if (is_err) begin
      r_op   = erspl_pkg::OP_NONE;
      r_addr = '0;
      r_cnt  = '0;
    end else begin
      r_op   = slot_opcode(slot_r);
      r_addr = addr_r & erspl_pkg::RUN_ADDR_MASK;
      r_cnt  = cur_r.cnt[slot_r];
    end
  end

  // Step the sequencer, load the next plan, fill the output register
  always_comb begin
    busy_nxt      = busy_r;
    slot_nxt      = slot_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (step) begin
      slot_nxt = slot_r + 1'b1;
      addr_nxt = addr_r + span;
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {{erspl_pkg::OUT_PAD_W{1'b0}}, cur_r.err, r_cnt, r_addr, r_op};
        out_last_nxt  = final_slot;
      end
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
    if (plan_valid && plan_ready) begin
      busy_nxt = 1'b1;
      slot_nxt = erspl_pkg::SLOT_HEAD_S;
      addr_nxt = plan.off;
      cur_nxt  = plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      slot_r      <= erspl_pkg::SLOT_HEAD_S;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/flash_erase_range_splitter.sv
`timescale 1ns / 1ps
// Top level of the flash erase range splitter.
//
// Each request (start offset, length) is checked and split into runs of
// 4K sector (0x20), 32K block (0x52) and 64K block (0xd8) erases, given as
// opcode, first address and command count, with tlast on the final run. A
// request with an offset off 4K, a length below 4K or a length off 4K gives
// one result with opcode 0 and the error code. A two-stage front end checks
// and splits the request and hands a plan through a two-entry queue to a run
// sequencer, which steps through five run slots, one per cycle unless a run
// waits on a stalled output, up to the last slot in use (only the head
// sector slot for a rejected request); that sequencer sets the sustained
// rate. With the queue empty and the output free, the first result passes
// the stage one registers, a queue entry, the sequencer plan register and
// the output register; each empty slot before the first run delays it.
// Stalls on the output hold only the sequencer; the front end keeps taking
// requests until the queue fills.
module flash_erase_range_splitter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [24:0] start_offset, [50:25] erase_length, [55:51] zero
  input  logic [erspl_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] opcode, [32:8] run_address, [42:33] command_count,
  // [44:43] error_code, [47:45] zero
  output logic [erspl_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                              out_tlast
);

  logic             f_valid;
  logic             f_ready;
  erspl_pkg::plan_t f_plan;
  logic             q_valid;
  logic             q_ready;
  erspl_pkg::plan_t q_plan;

  erspl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .plan_valid (f_valid),
    .plan_ready (f_ready),
    .plan       (f_plan)
  );

  erspl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_plan),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_plan)
  );

  erspl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan_valid (q_valid),
    .plan_ready (q_ready),
    .plan       (q_plan),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // A rejection is a single, empty, final result
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[44:43] != erspl_pkg::ERR_NONE) |->
      out_tlast && (out_tdata[7:0] == erspl_pkg::OP_NONE) && (out_tdata[42:33] == '0))
    else $error("rejected request result is not a single empty run");

  // Accepted requests only give real runs
  a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[44:43] == erspl_pkg::ERR_NONE) |->
      (out_tdata[42:33] != '0) && (out_tdata[7:0] != erspl_pkg::OP_NONE))
    else $error("run result with zero count or no opcode");

  // Every valid plan ends on a slot that carries a run
  a_plan_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |->
      (q_plan.err != erspl_pkg::ERR_NONE) || (q_plan.cnt[q_plan.last_slot] != '0))
    else $error("plan last slot carries no run");
`endif

endmodule
